FILE: hdl/mpwm_pkg.sv
// Shared types, constants and helper functions of the multi-pattern window match counter.
package mpwm_pkg;

	localparam int PATTERN_COUNT  = 16;
	localparam int PATTERN_LENGTH = 8;

	localparam int BYTE_W   = 8;
	localparam int SEL_W    = 4;
	localparam int OFS_W    = 3;
	localparam int COUNT_W  = 5;
	localparam int OFFSET_W = 16;
	localparam int FILL_W   = $clog2(PATTERN_LENGTH + 1);
	localparam int IDX_W    = (PATTERN_LENGTH > 1) ? $clog2(PATTERN_LENGTH) : 1;

	typedef enum logic [0:0] {
		OP_DATA        = 1'b0,
		OP_TABLE_WRITE = 1'b1
	} opcode_t;

	// Index 0 holds the oldest byte of the window.
	typedef logic [PATTERN_LENGTH-1:0][BYTE_W-1:0] window_t;

	// One transaction as it travels down the row of cells.
	typedef struct packed {
		logic                is_write;
		logic                report;
		window_t             window;
		logic [COUNT_W-1:0]  count;
		logic [OFFSET_W-1:0] start;
		logic [SEL_W-1:0]    sel;
		logic [OFS_W-1:0]    ofs;
		logic [BYTE_W-1:0]   value;
	} chain_tx_t;

	// Contents of a pattern after reset: byte 0 of pattern 0 is one, all else zero.
	function automatic window_t init_pattern(input logic [SEL_W-1:0] idx);
		window_t pat;
		pat = '0;
		if (idx == '0) begin
			pat[0] = BYTE_W'(1);
		end
		return pat;
	endfunction

endpackage

FILE: hdl/multi_pattern_window_match_count.sv
// Top level: window front end feeding a row of pattern cells, one result per window.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | opcode, byte_value, pattern_select,
//           |           |                        | pattern_offset, restart
//   out     | output    | out_valid / out_ready  | match_count, window_start
//
// One input transaction per cycle is accepted while in_ready is high. A transaction
// that gives a result passes through each cell's register before it leaves. Table
// writes travel down the row in order with the data, so each result sees exactly
// the table writes accepted before it. Reset clears the window and offset and
// restores the pattern table at once. A stalled output holds the last cell; earlier
// cells keep moving into empty slots, so input stalls only once the row is full.
module multi_pattern_window_match_count
	import mpwm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                opcode,
	input  logic [BYTE_W-1:0]   byte_value,
	input  logic [SEL_W-1:0]    pattern_select,
	input  logic [OFS_W-1:0]    pattern_offset,
	input  logic                restart,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [COUNT_W-1:0]  match_count,
	output logic [OFFSET_W-1:0] window_start
);

	logic      link_valid [PATTERN_COUNT+1];
	logic      link_ready [PATTERN_COUNT+1];
	chain_tx_t link_tx    [PATTERN_COUNT+1];

	mpwm_window u_window (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.byte_value     (byte_value),
		.pattern_select (pattern_select),
		.pattern_offset (pattern_offset),
		.restart        (restart),
		.tx_valid       (link_valid[0]),
		.tx_ready       (link_ready[0]),
		.tx             (link_tx[0])
	);

	for (genvar k = 0; k < PATTERN_COUNT; k++) begin : g_cell
		mpwm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_index (SEL_W'(k)),
			.init_value (init_pattern(SEL_W'(k))),
			.in_valid   (link_valid[k]),
			.in_ready   (link_ready[k]),
			.in_tx      (link_tx[k]),
			.out_valid  (link_valid[k+1]),
			.out_ready  (link_ready[k+1]),
			.out_tx     (link_tx[k+1])
		);
	end

	// Table writes leave the last cell without producing a result.
	assign out_valid                 = link_valid[PATTERN_COUNT] && link_tx[PATTERN_COUNT].report;
	assign link_ready[PATTERN_COUNT] = out_ready || !link_tx[PATTERN_COUNT].report;
	assign match_count               = link_tx[PATTERN_COUNT].count;
	assign window_start              = link_tx[PATTERN_COUNT].start;

endmodule

FILE: hdl/mpwm_window.sv
// Front end: sliding window, fill level and batch offset, building chain transactions.
module mpwm_window
	import mpwm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                opcode,
	input  logic [BYTE_W-1:0]   byte_value,
	input  logic [SEL_W-1:0]    pattern_select,
	input  logic [OFS_W-1:0]    pattern_offset,
	input  logic                restart,
	output logic                tx_valid,
	input  logic                tx_ready,
	output chain_tx_t           tx
);

	window_t             window_q;
	logic [FILL_W-1:0]   fill_q;
	logic [OFFSET_W-1:0] offset_q;

	window_t             window_n;
	logic [FILL_W-1:0]   base_fill;
	logic [FILL_W-1:0]   fill_n;
	logic [OFFSET_W-1:0] base_offset;
	logic                is_write;
	logic                report;
	logic                accept;

	assign in_ready = tx_ready;
	assign accept   = in_valid && tx_ready;
	assign is_write = (opcode == OP_TABLE_WRITE);

	always_comb begin
		base_fill   = restart ? '0 : fill_q;
		base_offset = restart ? '0 : offset_q;
		window_n    = window_q;
		if (base_fill < FILL_W'(PATTERN_LENGTH)) begin
			window_n[base_fill[IDX_W-1:0]] = byte_value;
			fill_n = base_fill + FILL_W'(1);
		end else begin
			for (int i = 0; i < PATTERN_LENGTH - 1; i++) begin
				window_n[i] = window_q[i + 1];
			end
			window_n[PATTERN_LENGTH-1] = byte_value;
			fill_n = base_fill;
		end
		report = (fill_n == FILL_W'(PATTERN_LENGTH));
	end

	always_comb begin
		tx.is_write = is_write;
		tx.report   = !is_write && report;
		tx.window   = window_n;
		tx.count    = '0;
		tx.start    = base_offset;
		tx.sel      = pattern_select;
		tx.ofs      = pattern_offset;
		tx.value    = byte_value;
	end

	// Data bytes that only fill the window never enter the chain.
	assign tx_valid = in_valid && (is_write || report);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q   <= '0;
			offset_q <= '0;
		end else if (accept && !is_write) begin
			window_q <= window_n;
			fill_q   <= fill_n;
			offset_q <= report ? base_offset + OFFSET_W'(1) : base_offset;
		end
	end

endmodule

FILE: hdl/mpwm_cell.sv
// One cell of the row: holds one pattern, applies its table writes and adds its match.
module mpwm_cell
	import mpwm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [SEL_W-1:0] cell_index,
	input  window_t          init_value,
	input  logic             in_valid,
	output logic             in_ready,
	input  chain_tx_t        in_tx,
	output logic             out_valid,
	input  logic             out_ready,
	output chain_tx_t        out_tx
);

	// The pattern is stored as its difference from the reset contents, so reset clears it.
	window_t   delta_q;
	logic      valid_q;
	chain_tx_t tx_q;

	window_t   pattern;
	logic      capture;
	logic      hit;
	chain_tx_t tx_n;

	assign pattern   = delta_q ^ init_value;
	assign in_ready  = !valid_q || out_ready;
	assign capture   = in_valid && in_ready;
	assign out_valid = valid_q;
	assign out_tx    = tx_q;

	always_comb begin
		hit        = in_tx.report && (pattern == in_tx.window);
		tx_n       = in_tx;
		tx_n.count = in_tx.count + COUNT_W'(hit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			delta_q <= '0;
		end else begin
			if (in_ready) begin
				valid_q <= in_valid;
			end
			if (capture && in_tx.is_write && in_tx.sel == cell_index
					&& int'(in_tx.ofs) < PATTERN_LENGTH) begin
				delta_q[in_tx.ofs[IDX_W-1:0]] <= in_tx.value ^ init_value[in_tx.ofs[IDX_W-1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			tx_q <= tx_n;
		end
	end

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the multi-pattern window match counter.
`timescale 1ns / 1ps

module testbench;
	import mpwm_pkg::*;

	localparam int HOLD_CYCLES   = 250;
	localparam int RANDOM_ITEMS  = 760;
	localparam int STEADY_ITEMS  = 160;

	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [OFFSET_W-1:0] start;
	} scan_result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                opcode;
	logic [BYTE_W-1:0]   byte_value;
	logic [SEL_W-1:0]    pattern_select;
	logic [OFS_W-1:0]    pattern_offset;
	logic                restart;
	logic                out_valid;
	logic                out_ready;
	logic [COUNT_W-1:0]  match_count;
	logic [OFFSET_W-1:0] window_start;

	// Scanner state as the testbench sees it.
	logic [BYTE_W-1:0]   pattern_table [PATTERN_COUNT][PATTERN_LENGTH];
	logic [BYTE_W-1:0]   scan_window [PATTERN_LENGTH];
	int                  scan_fill;
	logic [OFFSET_W-1:0] scan_offset;

	scan_result_t        pending_results[$];
	int                  transactions_sent;
	int                  results_checked;
	int                  error_count;
	int                  peak_match_count;
	bit                  bursts_on;
	bit                  hold_request;

	multi_pattern_window_match_count dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.byte_value     (byte_value),
		.pattern_select (pattern_select),
		.pattern_offset (pattern_offset),
		.restart        (restart),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.match_count    (match_count),
		.window_start   (window_start)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic void clear_scanner();
		for (int p = 0; p < PATTERN_COUNT; p++) begin
			for (int b = 0; b < PATTERN_LENGTH; b++) begin
				pattern_table[p][b] = '0;
			end
		end
		pattern_table[0][0] = BYTE_W'(1);
		for (int b = 0; b < PATTERN_LENGTH; b++) begin
			scan_window[b] = '0;
		end
		scan_fill   = 0;
		scan_offset = '0;
	endfunction

	// Applies one accepted transaction and queues the result it produces, if any.
	function automatic void advance_scanner(input opcode_t op, input logic [BYTE_W-1:0] val,
			input logic [SEL_W-1:0] sel, input logic [OFS_W-1:0] ofs, input logic rst);
		int           hits;
		bit           same;
		scan_result_t res;
		if (op == OP_TABLE_WRITE) begin
			if (int'(sel) < PATTERN_COUNT && int'(ofs) < PATTERN_LENGTH) begin
				pattern_table[sel][ofs] = val;
			end
			return;
		end
		if (rst) begin
			scan_fill   = 0;
			scan_offset = '0;
		end
		if (scan_fill < PATTERN_LENGTH) begin
			scan_window[scan_fill] = val;
			scan_fill++;
		end else begin
			for (int b = 0; b < PATTERN_LENGTH - 1; b++) begin
				scan_window[b] = scan_window[b + 1];
			end
			scan_window[PATTERN_LENGTH - 1] = val;
		end
		if (scan_fill < PATTERN_LENGTH) begin
			return;
		end
		hits = 0;
		for (int p = 0; p < PATTERN_COUNT; p++) begin
			same = 1'b1;
			for (int b = 0; b < PATTERN_LENGTH; b++) begin
				if (pattern_table[p][b] != scan_window[b]) begin
					same = 1'b0;
				end
			end
			if (same) begin
				hits++;
			end
		end
		res.count = COUNT_W'(hits);
		res.start = scan_offset;
		pending_results.push_back(res);
		scan_offset = scan_offset + OFFSET_W'(1);
	endfunction

	function automatic void report_mismatch(input string what, input int expected_value,
			input int actual_value);
		$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what,
			expected_value, actual_value);
		error_count++;
	endfunction

	// Picks a byte that is often drawn from a small set so that windows repeat.
	function automatic logic [BYTE_W-1:0] pick_byte();
		logic [BYTE_W-1:0] common [5] = '{8'h00, 8'h01, 8'h55, 8'hAA, 8'hFF};
		if ($urandom_range(0, 1) == 0) begin
			return common[$urandom_range(0, 4)];
		end
		return BYTE_W'($urandom);
	endfunction

	task automatic send_transaction(input opcode_t op, input logic [BYTE_W-1:0] val,
			input logic [SEL_W-1:0] sel, input logic [OFS_W-1:0] ofs, input logic rst);
		in_valid       <= 1'b1;
		opcode         <= op;
		byte_value     <= val;
		pattern_select <= sel;
		pattern_offset <= ofs;
		restart        <= rst;
		@(posedge clk);
		while (in_ready !== 1'b1) begin
			@(posedge clk);
		end
		advance_scanner(op, val, sel, ofs, rst);
		transactions_sent++;
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic send_data(input logic [BYTE_W-1:0] val, input logic rst);
		send_transaction(OP_DATA, val, SEL_W'($urandom), OFS_W'($urandom), rst);
	endtask

	// Pattern 0 after reset starts with a one; the other patterns are all zero.
	task automatic test_reset_table();
		send_data(8'h01, 1'b1);
		for (int b = 1; b < PATTERN_LENGTH; b++) begin
			send_data(8'h00, 1'b0);
		end
		send_data(8'h00, 1'b0);
	endtask

	// Clearing pattern 0 makes every pattern match the zero window.
	task automatic test_table_write();
		send_transaction(OP_TABLE_WRITE, 8'h00, '0, '0, 1'b1);
		send_data(8'h00, 1'b0);
		send_transaction(OP_TABLE_WRITE, 8'hFF, SEL_W'(PATTERN_COUNT - 1),
			OFS_W'(PATTERN_LENGTH - 1), 1'b0);
		send_data(8'hFF, 1'b0);
	endtask

	// Restart on a full window, then again while the window is still filling.
	task automatic test_restart();
		logic [BYTE_W-1:0] seq [11] = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE,
			8'h55, 8'hAA, 8'h33, 8'hCC, 8'h0F};
		for (int i = 0; i < 11; i++) begin
			send_data(seq[i], (i == 0 || i == 3));
		end
	endtask

	task automatic test_random_stream();
		int goal;
		int kind;
		int p;
		int q;
		int len;
		goal = transactions_sent + RANDOM_ITEMS;
		while (transactions_sent < goal) begin
			kind = $urandom_range(0, 9);
			if (kind <= 3) begin
				// Replay a stored pattern so that the window matches it.
				p = $urandom_range(0, PATTERN_COUNT - 1);
				for (int b = 0; b < PATTERN_LENGTH; b++) begin
					send_data(pattern_table[p][b], (b == 0 && $urandom_range(0, 7) == 0));
				end
			end else if (kind <= 5) begin
				// Program a whole pattern, sometimes as a copy of another one.
				p = $urandom_range(0, PATTERN_COUNT - 1);
				q = $urandom_range(0, PATTERN_COUNT - 1);
				for (int b = 0; b < PATTERN_LENGTH; b++) begin
					send_transaction(OP_TABLE_WRITE,
						(kind == 4) ? pattern_table[q][b] : pick_byte(),
						SEL_W'(p), OFS_W'(b), 1'($urandom));
				end
			end else if (kind == 6) begin
				send_transaction(OP_TABLE_WRITE, BYTE_W'($urandom), SEL_W'($urandom),
					OFS_W'($urandom), 1'($urandom));
			end else if (kind <= 8) begin
				len = $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					send_data(pick_byte(), ($urandom_range(0, 9) == 0));
				end
			end else begin
				len = $urandom_range(0, 9);
				send_data(pick_byte(), 1'b1);
				for (int i = 0; i < len; i++) begin
					send_data(pick_byte(), 1'b0);
				end
			end
		end
	endtask

	// The receiver holds off for a long stretch while data keeps coming.
	task automatic test_backpressure();
		hold_request = 1'b1;
		for (int i = 0; i < 60; i++) begin
			send_data(pick_byte(), 1'b0);
		end
	endtask

	// A final stretch of data with no idling on either side.
	task automatic test_steady_stream();
		send_data(pick_byte(), 1'b1);
		for (int i = 1; i < STEADY_ITEMS; i++) begin
			send_data(pick_byte(), 1'b0);
		end
	endtask

	initial begin
		int drain_cycles;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		opcode         = OP_DATA;
		byte_value     = '0;
		pattern_select = '0;
		pattern_offset = '0;
		restart        = 1'b0;
		bursts_on      = 1'b1;
		hold_request   = 1'b0;
		clear_scanner();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_table();
		test_table_write();
		test_restart();
		test_random_stream();
		test_backpressure();
		bursts_on = 1'b0;
		test_steady_stream();
		in_valid <= 1'b0;

		drain_cycles = 0;
		while (pending_results.size() != 0 && drain_cycles < 4000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (2 * PATTERN_COUNT) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t ns: %0d expected results never arrived", $time,
				pending_results.size());
			error_count++;
		end

		$display("Sent %0d transactions and checked %0d window results.",
			transactions_sent, results_checked);
		$display("Highest match count seen %0d, errors: %0d.",
			peak_match_count, error_count);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Receiver: random stall bursts, one long hold on request, steady when bursts are off.
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (bursts_on && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected result, count %0d, start %0d", $time,
					match_count, window_start);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (match_count !== want.count) begin
					report_mismatch("match_count", want.count, match_count);
				end
				if (window_start !== want.start) begin
					report_mismatch("window_start", want.start, window_start);
				end
				if (int'(want.count) > peak_match_count) begin
					peak_match_count = want.count;
				end
				results_checked++;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results still expected.", pending_results.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: multi_pattern_window_match_count.f
hdl/mpwm_pkg.sv
hdl/mpwm_window.sv
hdl/mpwm_cell.sv
hdl/multi_pattern_window_match_count.sv
test/testbench.sv
